// File: rtl/tms_pkg.sv
// Package for the text macro substitution block: shared types, codes and
// character class helpers. No dependencies.
package tms_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int KEY_CHARS_DEF     = 32;
    localparam int VALUE_CHARS_DEF   = 32;

    // Word lengths saturate at 63.
    localparam int          LEN_W   = 6;
    localparam logic [5:0]  LEN_MAX = 6'd63;
    localparam logic [2:0]  PREFIX_LAST = 3'd6;
    localparam logic [7:0]  CH_LF  = 8'h0A;

    typedef enum logic [1:0] {
        STAT_NONE = 2'd0,
        STAT_FULL = 2'd1,
        STAT_LONG = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_TEXT    = 3'd1,
        PH_SKIP    = 3'd2,
        PH_GAP_KEY = 3'd3,
        PH_KEY     = 3'd4,
        PH_GAP_VAL = 3'd5,
        PH_VAL     = 3'd6,
        PH_REST    = 3'd7
    } phase_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       has_char;
        status_t    status;
    } res_t;

    function automatic logic is_word(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A) || (c == 8'h5F);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
               (c == 8'h0C) || (c == 8'h0D);
    endfunction

    // Characters of the "$DEFINE" line prefix.
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h24;
            3'd1:    c = 8'h44;
            3'd2:    c = 8'h45;
            3'd3:    c = 8'h46;
            3'd4:    c = 8'h49;
            3'd5:    c = 8'h4E;
            3'd6:    c = 8'h45;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/text_macro_substitution.sv
// Text macro substitution, top level: byte sequencer, dictionary memories
// and the result output stage. Depends on tms_pkg, tms_dict and tms_ctrl.
// A byte is accepted only once the previous byte is finished. A token end
// scans the stored entries, comparing key bytes, then reads out the value
// bytes, all through the one-byte-a-cycle dictionary read port; a stalled
// downstream holds every beat.
// Reset is asynchronous and active low; the memories need no clearing pass,
// the entry count simply restarts at zero.
module text_macro_substitution
    import tms_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int KEY_CHARS     = KEY_CHARS_DEF,
    parameter int VALUE_CHARS   = VALUE_CHARS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_char
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_char [7:0], status [9:8], zero above
    output logic        m_tuser,   // has_char
    output logic        m_tlast    // last_of_run
);

    localparam int DEPTH = TABLE_ENTRIES * (KEY_CHARS + VALUE_CHARS);
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic               go;
    logic               emit_vld;
    logic               done_vld;
    res_t               emit_res;
    logic               char_we;
    logic [AW-1:0]      char_waddr;
    logic [7:0]         char_wdata;
    logic [AW-1:0]      char_raddr;
    logic [7:0]         char_rdata;
    logic               len_we;
    logic [LW-1:0]      len_waddr;
    logic [2*LEN_W-1:0] len_wdata;
    logic [LW-1:0]      len_raddr;
    logic [2*LEN_W-1:0] len_rdata;

    // The newest result waits in a hold register until either another result
    // follows (it leaves with last_of_run low) or the byte is finished (it
    // leaves with last_of_run high). The output register behind it parts the
    // sequencer from the downstream ready.
    logic               hold_vld_reg;
    res_t               hold_reg;
    logic               out_vld_reg;
    res_t               out_reg;
    logic               out_last_reg;
    logic               push;

    assign go   = !out_vld_reg || m_tready;
    assign push = go && (emit_vld || done_vld) && hold_vld_reg;

    tms_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .KEY_CHARS     (KEY_CHARS),
        .VALUE_CHARS   (VALUE_CHARS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_char    (s_tdata),
        .in_last    (s_tlast),
        .go         (go),
        .emit_vld   (emit_vld),
        .done_vld   (done_vld),
        .emit_res   (emit_res),
        .char_we    (char_we),
        .char_waddr (char_waddr),
        .char_wdata (char_wdata),
        .char_raddr (char_raddr),
        .char_rdata (char_rdata),
        .len_we     (len_we),
        .len_waddr  (len_waddr),
        .len_wdata  (len_wdata),
        .len_raddr  (len_raddr),
        .len_rdata  (len_rdata)
    );

    tms_dict #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .KEY_CHARS     (KEY_CHARS),
        .VALUE_CHARS   (VALUE_CHARS)
    ) u_dict (
        .clk        (clk),
        .char_we    (char_we),
        .char_waddr (char_waddr),
        .char_wdata (char_wdata),
        .char_raddr (char_raddr),
        .char_rdata (char_rdata),
        .len_we     (len_we),
        .len_waddr  (len_waddr),
        .len_wdata  (len_wdata),
        .len_raddr  (len_raddr),
        .len_rdata  (len_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (push)
                out_vld_reg <= 1'b1;
            else if (m_tready)
                out_vld_reg <= 1'b0;
            if (go && emit_vld)
                hold_vld_reg <= 1'b1;
            else if (go && done_vld)
                hold_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_reg      <= hold_reg;
            out_last_reg <= done_vld;
        end
        if (go && emit_vld)
            hold_reg <= emit_res;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, out_reg.status, out_reg.out_char};
    assign m_tuser  = out_reg.has_char;
    assign m_tlast  = out_last_reg;

    // A byte is only taken once every result of the previous one has left
    // the hold register.
    a_idle_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !hold_vld_reg)
        else $error("hold register occupied while accepting a byte");

    a_emit_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(emit_vld && done_vld))
        else $error("result and end of byte issued together");

    a_status_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> ((m_tdata[7:0] == 8'd0) && (m_tdata[9:8] != 2'd0)))
        else $error("status beat carries a character or no status");

    a_text_no_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[9:8] == 2'd0))
        else $error("text beat carries a status code");

endmodule

// File: rtl/tms_dict.sv
// Macro dictionary storage: one character memory holding key and value text
// per entry, and one length memory. Depends on tms_pkg.
module tms_dict
    import tms_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int KEY_CHARS     = KEY_CHARS_DEF,
    parameter int VALUE_CHARS   = VALUE_CHARS_DEF,
    localparam int DEPTH = TABLE_ENTRIES * (KEY_CHARS + VALUE_CHARS),
    localparam int AW    = $clog2(DEPTH),
    localparam int LW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
)
(
    input  logic                 clk,
    input  logic                 char_we,
    input  logic [AW-1:0]        char_waddr,
    input  logic [7:0]           char_wdata,
    input  logic [AW-1:0]        char_raddr,
    output logic [7:0]           char_rdata,
    input  logic                 len_we,
    input  logic [LW-1:0]        len_waddr,
    input  logic [2*LEN_W-1:0]   len_wdata,
    input  logic [LW-1:0]        len_raddr,
    output logic [2*LEN_W-1:0]   len_rdata
);

    logic [7:0]         char_mem [DEPTH];
    logic [2*LEN_W-1:0] len_mem  [TABLE_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (char_we)
        begin
            char_mem[char_waddr] <= char_wdata;
        end
        char_rdata <= char_mem[char_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[len_waddr] <= len_wdata;
        end
        len_rdata <= len_mem[len_raddr];
    end

endmodule

// File: rtl/tms_ctrl.sv
// Byte sequencer for the macro processor: line parsing, token buffering,
// dictionary lookup and definition capture. Depends on tms_pkg.
module tms_ctrl
    import tms_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int KEY_CHARS     = KEY_CHARS_DEF,
    parameter int VALUE_CHARS   = VALUE_CHARS_DEF,
    localparam int DEPTH = TABLE_ENTRIES * (KEY_CHARS + VALUE_CHARS),
    localparam int AW    = $clog2(DEPTH),
    localparam int LW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_char,
    input  logic                 in_last,
    input  logic                 go,
    output logic                 emit_vld,
    output logic                 done_vld,
    output res_t                 emit_res,
    output logic                 char_we,
    output logic [AW-1:0]        char_waddr,
    output logic [7:0]           char_wdata,
    output logic [AW-1:0]        char_raddr,
    input  logic [7:0]           char_rdata,
    output logic                 len_we,
    output logic [LW-1:0]        len_waddr,
    output logic [2*LEN_W-1:0]   len_wdata,
    output logic [LW-1:0]        len_raddr,
    input  logic [2*LEN_W-1:0]   len_rdata
);

    localparam int EC_W = $clog2(TABLE_ENTRIES + 1);
    localparam int KW   = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1;
    localparam logic [AW-1:0]   KEY_AW    = AW'(KEY_CHARS);
    localparam logic [AW-1:0]   STRIDE_AW = AW'(KEY_CHARS + VALUE_CHARS);
    localparam logic [EC_W-1:0] TABLE_EC  = EC_W'(TABLE_ENTRIES);
    localparam logic [5:0]      KEY_L     = 6'(KEY_CHARS);
    localparam logic [5:0]      VAL_L     = 6'(VALUE_CHARS);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_DISP   = 14'b00000000000010,
        S_TEXT   = 14'b00000000000100,
        S_DUMP   = 14'b00000000001000,
        S_EMITC  = 14'b00000000010000,
        S_NEXT   = 14'b00000000100000,
        S_FLUSH  = 14'b00000001000000,
        S_LK_LEN = 14'b00000010000000,
        S_LK_LW  = 14'b00000100000000,
        S_LK_CMP = 14'b00001000000000,
        S_VAL    = 14'b00010000000000,
        S_COMMIT = 14'b00100000000000,
        S_EOI    = 14'b01000000000000,
        S_DONE   = 14'b10000000000000
    } state_t;

    state_t          state_reg, state_next;
    phase_t          phase_reg, phase_next;
    logic [2:0]      pm_reg, pm_next;
    logic [5:0]      tl_reg, tl_next;
    logic            ovf_reg, ovf_next;
    logic            err_reg, err_next;
    logic [EC_W-1:0] ec_reg, ec_next;
    logic [AW-1:0]   wbase_reg, wbase_next;
    logic [5:0]      klen_reg, klen_next;
    logic [7:0]      c_reg, c_next;
    logic            last_reg, last_next;
    logic [2:0]      rep_cnt_reg, rep_cnt_next;
    logic [2:0]      rep_pm_reg, rep_pm_next;
    logic [2:0]      rep_tot_reg, rep_tot_next;
    logic            eoi_reg, eoi_next;
    logic            fin_reg, fin_next;
    logic [EC_W-1:0] i_reg, i_next;
    logic [AW-1:0]   sbase_reg, sbase_next;
    logic [5:0]      k_reg, k_next;
    logic [5:0]      vlen_reg, vlen_next;

    logic [7:0]      tbuf [KEY_CHARS];
    logic            tbuf_we;
    logic [7:0]      tb;
    logic [7:0]      tbuf_k;
    logic            nl;
    logic            do_word;
    logic            key_side;
    logic [5:0]      cap;
    state_t          after_flush;

    assign tb          = (rep_cnt_reg < rep_pm_reg) ? prefix_char(rep_cnt_reg) : c_reg;
    assign tbuf_k      = tbuf[k_reg[KW-1:0]];
    assign in_ready    = (state_reg == S_IDLE);
    assign after_flush = fin_reg ? S_DONE : S_EMITC;
    assign key_side    = (phase_reg == PH_GAP_KEY) || (phase_reg == PH_KEY);
    assign cap         = key_side ? KEY_L : VAL_L;

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        pm_next      = pm_reg;
        tl_next      = tl_reg;
        ovf_next     = ovf_reg;
        err_next     = err_reg;
        ec_next      = ec_reg;
        wbase_next   = wbase_reg;
        klen_next    = klen_reg;
        c_next       = c_reg;
        last_next    = last_reg;
        rep_cnt_next = rep_cnt_reg;
        rep_pm_next  = rep_pm_reg;
        rep_tot_next = rep_tot_reg;
        eoi_next     = eoi_reg;
        fin_next     = fin_reg;
        i_next       = i_reg;
        sbase_next   = sbase_reg;
        k_next       = k_reg;
        vlen_next    = vlen_reg;
        nl           = 1'b0;
        do_word      = 1'b0;
        tbuf_we      = 1'b0;
        emit_vld     = 1'b0;
        done_vld     = 1'b0;
        emit_res     = '{out_char: tb, has_char: 1'b1, status: STAT_NONE};
        char_we      = 1'b0;
        char_waddr   = AW'(wbase_reg + (key_side ? AW'(0) : KEY_AW) + AW'(tl_reg));
        char_wdata   = c_reg;
        char_raddr   = AW'(sbase_reg + KEY_AW + AW'(k_reg));
        len_we       = 1'b0;
        len_waddr    = ec_reg[LW-1:0];
        len_wdata    = {klen_reg, tl_reg};
        len_raddr    = i_reg[LW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    c_next     = in_char;
                    last_next  = in_last;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                eoi_next   = 1'b0;
                fin_next   = 1'b0;
                state_next = S_EOI;
                case (phase_reg)
                    PH_START:
                    begin
                        if (c_reg == prefix_char(pm_reg))
                        begin
                            if (pm_reg == PREFIX_LAST)
                            begin
                                pm_next    = 3'd0;
                                phase_next = PH_SKIP;
                            end
                            else
                            begin
                                pm_next = pm_reg + 3'd1;
                            end
                        end
                        else
                        begin
                            // Held prefix bytes replay as text, then this byte.
                            rep_pm_next  = pm_reg;
                            rep_tot_next = pm_reg + 3'd1;
                            rep_cnt_next = 3'd0;
                            pm_next      = 3'd0;
                            phase_next   = PH_TEXT;
                            state_next   = S_TEXT;
                        end
                    end
                    PH_TEXT:
                    begin
                        rep_pm_next  = 3'd0;
                        rep_tot_next = 3'd1;
                        rep_cnt_next = 3'd0;
                        state_next   = S_TEXT;
                    end
                    PH_SKIP:
                    begin
                        if (c_reg == CH_LF)
                            nl = 1'b1;
                        else
                            phase_next = PH_GAP_KEY;
                    end
                    PH_GAP_KEY, PH_GAP_VAL:
                    begin
                        if (c_reg == CH_LF)
                        begin
                            nl = 1'b1;
                        end
                        else if (!is_space(c_reg))
                        begin
                            do_word    = 1'b1;
                            phase_next = key_side ? PH_KEY : PH_VAL;
                        end
                    end
                    PH_KEY:
                    begin
                        if (is_space(c_reg))
                        begin
                            klen_next = tl_reg;
                            tl_next   = 6'd0;
                            if (c_reg == CH_LF)
                                nl = 1'b1;
                            else
                                phase_next = PH_GAP_VAL;
                        end
                        else
                        begin
                            do_word = 1'b1;
                        end
                    end
                    PH_VAL:
                    begin
                        if (is_space(c_reg))
                            state_next = S_COMMIT;
                        else
                            do_word = 1'b1;
                    end
                    default:
                    begin
                        if (c_reg == CH_LF)
                            nl = 1'b1;
                    end
                endcase
            end
            S_TEXT:
            begin
                if (is_word(tb))
                begin
                    if (ovf_reg)
                    begin
                        state_next = S_EMITC;
                    end
                    else if (tl_reg < KEY_L)
                    begin
                        tbuf_we    = 1'b1;
                        tl_next    = tl_reg + 6'd1;
                        state_next = S_NEXT;
                    end
                    else
                    begin
                        ovf_next   = 1'b1;
                        k_next     = 6'd0;
                        state_next = S_DUMP;
                    end
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_DUMP:
            begin
                emit_vld          = 1'b1;
                emit_res.out_char = tbuf_k;
                if (go)
                begin
                    if ((k_reg + 6'd1) == tl_reg)
                    begin
                        tl_next    = 6'd0;
                        state_next = after_flush;
                    end
                    else
                    begin
                        k_next = k_reg + 6'd1;
                    end
                end
            end
            S_EMITC:
            begin
                emit_vld = 1'b1;
                if (go)
                    state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (({1'b0, rep_cnt_reg} + 4'd1) < {1'b0, rep_tot_reg})
                begin
                    rep_cnt_next = rep_cnt_reg + 3'd1;
                    state_next   = S_TEXT;
                end
                else if (eoi_reg)
                begin
                    fin_next   = 1'b1;
                    state_next = S_FLUSH;
                end
                else
                begin
                    if (c_reg == CH_LF)
                        nl = 1'b1;
                    state_next = S_EOI;
                end
            end
            S_FLUSH:
            begin
                if (ovf_reg)
                begin
                    ovf_next   = 1'b0;
                    tl_next    = 6'd0;
                    state_next = after_flush;
                end
                else if (tl_reg == 6'd0)
                begin
                    state_next = after_flush;
                end
                else
                begin
                    i_next     = '0;
                    sbase_next = '0;
                    state_next = S_LK_LEN;
                end
            end
            S_LK_LEN:
            begin
                if (i_reg >= ec_reg)
                begin
                    k_next     = 6'd0;
                    state_next = S_DUMP;
                end
                else
                begin
                    state_next = S_LK_LW;
                end
            end
            S_LK_LW:
            begin
                vlen_next = len_rdata[LEN_W-1:0];
                if (len_rdata[2*LEN_W-1:LEN_W] == tl_reg)
                begin
                    k_next     = 6'd0;
                    char_raddr = sbase_reg;
                    state_next = S_LK_CMP;
                end
                else
                begin
                    i_next     = i_reg + EC_W'(1);
                    sbase_next = AW'(sbase_reg + STRIDE_AW);
                    state_next = S_LK_LEN;
                end
            end
            S_LK_CMP:
            begin
                if (char_rdata != tbuf_k)
                begin
                    i_next     = i_reg + EC_W'(1);
                    sbase_next = AW'(sbase_reg + STRIDE_AW);
                    state_next = S_LK_LEN;
                end
                else if ((k_reg + 6'd1) == tl_reg)
                begin
                    k_next     = 6'd0;
                    char_raddr = AW'(sbase_reg + KEY_AW);
                    state_next = S_VAL;
                end
                else
                begin
                    k_next     = k_reg + 6'd1;
                    char_raddr = AW'(sbase_reg + AW'(k_reg) + AW'(1));
                end
            end
            S_VAL:
            begin
                emit_vld          = 1'b1;
                emit_res.out_char = char_rdata;
                if (go)
                begin
                    char_raddr = AW'(sbase_reg + KEY_AW + AW'(k_reg) + AW'(1));
                    if ((k_reg + 6'd1) == vlen_reg)
                    begin
                        tl_next    = 6'd0;
                        state_next = after_flush;
                    end
                    else
                    begin
                        k_next = k_reg + 6'd1;
                    end
                end
            end
            S_COMMIT:
            begin
                emit_res = '{out_char: 8'd0, has_char: 1'b0,
                             status: err_reg ? STAT_LONG : STAT_FULL};
                if (err_reg || (ec_reg >= TABLE_EC))
                begin
                    emit_vld = 1'b1;
                end
                else
                begin
                    len_we     = 1'b1;
                    ec_next    = ec_reg + EC_W'(1);
                    wbase_next = AW'(wbase_reg + STRIDE_AW);
                end
                if (go || !emit_vld)
                begin
                    tl_next = 6'd0;
                    if (eoi_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        if (c_reg == CH_LF)
                            nl = 1'b1;
                        else
                            phase_next = PH_REST;
                        state_next = S_EOI;
                    end
                end
            end
            S_EOI:
            begin
                state_next = S_DONE;
                if (last_reg)
                begin
                    eoi_next = 1'b1;
                    if ((phase_reg == PH_START) && (pm_reg != 3'd0))
                    begin
                        rep_pm_next  = pm_reg;
                        rep_tot_next = pm_reg;
                        rep_cnt_next = 3'd0;
                        pm_next      = 3'd0;
                        state_next   = S_TEXT;
                    end
                    else if (phase_reg == PH_TEXT)
                    begin
                        fin_next   = 1'b1;
                        state_next = S_FLUSH;
                    end
                    else if (phase_reg == PH_VAL)
                    begin
                        state_next = S_COMMIT;
                    end
                end
            end
            S_DONE:
            begin
                done_vld = 1'b1;
                if (go)
                begin
                    if (last_reg)
                        nl = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_word)
        begin
            char_we = (tl_reg < cap) && (ec_reg < TABLE_EC);
            if (tl_reg >= cap)
                err_next = 1'b1;
            if (tl_reg < LEN_MAX)
                tl_next = tl_reg + 6'd1;
        end

        if (nl)
        begin
            phase_next = PH_START;
            pm_next    = 3'd0;
            tl_next    = 6'd0;
            ovf_next   = 1'b0;
            err_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            phase_reg   <= PH_START;
            pm_reg      <= 3'd0;
            tl_reg      <= 6'd0;
            ovf_reg     <= 1'b0;
            err_reg     <= 1'b0;
            ec_reg      <= '0;
            wbase_reg   <= '0;
            last_reg    <= 1'b0;
            rep_cnt_reg <= 3'd0;
            rep_pm_reg  <= 3'd0;
            rep_tot_reg <= 3'd0;
            eoi_reg     <= 1'b0;
            fin_reg     <= 1'b0;
            i_reg       <= '0;
            sbase_reg   <= '0;
            k_reg       <= 6'd0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            pm_reg      <= pm_next;
            tl_reg      <= tl_next;
            ovf_reg     <= ovf_next;
            err_reg     <= err_next;
            ec_reg      <= ec_next;
            wbase_reg   <= wbase_next;
            last_reg    <= last_next;
            rep_cnt_reg <= rep_cnt_next;
            rep_pm_reg  <= rep_pm_next;
            rep_tot_reg <= rep_tot_next;
            eoi_reg     <= eoi_next;
            fin_reg     <= fin_next;
            i_reg       <= i_next;
            sbase_reg   <= sbase_next;
            k_reg       <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg     <= c_next;
        klen_reg  <= klen_next;
        vlen_reg  <= vlen_next;
        if (tbuf_we)
        begin
            tbuf[tl_reg[KW-1:0]] <= tb;
        end
    end

endmodule

// File: tb/text_macro_substitution_tb.sv
// Testbench for the text macro substitution block: directed and random byte
// streams, checked beat by beat against a behavioral predictor.
// Depends on tms_pkg and text_macro_substitution.
`timescale 1ns / 100ps

module text_macro_substitution_tb;
    import tms_pkg::*;

    localparam int NUM_ENTRIES = TABLE_ENTRIES_DEF;
    localparam int KEY_MAX     = KEY_CHARS_DEF;
    localparam int VAL_MAX     = VALUE_CHARS_DEF;
    localparam int MAX_BEATS   = 34;
    localparam int CYCLE_LIMIT = 20000000;
    localparam int DRAIN_CYCLES = 400;

    typedef struct {
        logic [7:0] ch;
        logic       has;
        status_t    st;
        logic       last;
    } beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // in_char
    logic        s_tlast = 1'b0;    // end_of_input
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // out_char [7:0], status [9:8], zero above
    logic        m_tuser;           // has_char
    logic        m_tlast;           // last_of_run

    // Shared controls: no_idle switches off the random gaps on both sides.
    bit          no_idle = 1'b0;
    int          errors = 0;
    int          bytes_sent = 0;
    int          cycles = 0;
    beat_t       expected_beats[$];
    beat_t       step_beats[$];

    // Predictor state: dictionary, the token being collected, line parsing.
    logic [7:0]  dict_keys [NUM_ENTRIES*KEY_MAX];
    logic [7:0]  dict_vals [NUM_ENTRIES*VAL_MAX];
    int          dict_klen [NUM_ENTRIES];
    int          dict_vlen [NUM_ENTRIES];
    int          dict_used;
    logic [7:0]  tok [KEY_MAX];
    int          tok_len;
    phase_t      phase;
    int          pre_hits;
    bit          tok_spill;
    int          def_err;
    logic [7:0]  define_word [7] = '{8'h24, 8'h44, 8'h45, 8'h46, 8'h49, 8'h4E, 8'h45};

    text_macro_substitution dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic bit is_ident(logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) || c == 8'h5F;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic void put(logic [7:0] ch, logic has, status_t st);
        beat_t b;
        if (step_beats.size() < MAX_BEATS) begin
            b.ch = ch;
            b.has = has;
            b.st = st;
            b.last = 1'b0;
            step_beats.push_back(b);
        end
    endfunction

    // A token ends: replace it by the first matching key's value, else echo it.
    function automatic void end_token();
        bit hit;
        hit = 1'b0;
        if (tok_spill) begin
            tok_spill = 1'b0;
        end else if (tok_len > 0) begin
            for (int i = 0; i < dict_used && !hit; i++) begin
                if (dict_klen[i] == tok_len) begin
                    hit = 1'b1;
                    for (int k = 0; k < tok_len; k++)
                        if (dict_keys[i*KEY_MAX+k] != tok[k]) hit = 1'b0;
                    if (hit)
                        for (int k = 0; k < dict_vlen[i] && k < VAL_MAX; k++)
                            put(dict_vals[i*VAL_MAX+k], 1'b1, STAT_NONE);
                end
            end
            if (!hit)
                for (int k = 0; k < tok_len; k++) put(tok[k], 1'b1, STAT_NONE);
        end
        tok_len = 0;
    endfunction

    function automatic void plain_char(logic [7:0] c);
        if (is_ident(c)) begin
            if (tok_spill) begin
                put(c, 1'b1, STAT_NONE);
            end else if (tok_len < KEY_MAX) begin
                tok[tok_len] = c;
                tok_len++;
            end else begin
                // The token outgrew the buffer: it can no longer match a key.
                for (int k = 0; k < tok_len; k++) put(tok[k], 1'b1, STAT_NONE);
                put(c, 1'b1, STAT_NONE);
                tok_spill = 1'b1;
                tok_len = 0;
            end
        end else begin
            end_token();
            put(c, 1'b1, STAT_NONE);
        end
    endfunction

    function automatic void replay_prefix();
        for (int k = 0; k < pre_hits; k++) plain_char(define_word[k]);
        pre_hits = 0;
    endfunction

    function automatic void def_char(logic [7:0] c, bit is_val);
        int cap;
        cap = is_val ? VAL_MAX : KEY_MAX;
        if (tok_len < cap && dict_used < NUM_ENTRIES) begin
            if (is_val) dict_vals[dict_used*VAL_MAX+tok_len] = c;
            else        dict_keys[dict_used*KEY_MAX+tok_len] = c;
        end
        if (tok_len >= cap) def_err = 2;
        if (tok_len < 63) tok_len++;
    endfunction

    function automatic void finish_define();
        if (def_err != 0) begin
            put(8'h00, 1'b0, STAT_LONG);
        end else if (dict_used >= NUM_ENTRIES) begin
            put(8'h00, 1'b0, STAT_FULL);
        end else begin
            dict_vlen[dict_used] = tok_len;
            dict_used++;
        end
        tok_len = 0;
    endfunction

    function automatic void line_reset();
        phase = PH_START;
        pre_hits = 0;
        tok_len = 0;
        tok_spill = 1'b0;
        def_err = 0;
    endfunction

    // Work out the beats one accepted byte causes and queue them.
    function automatic void predict_byte(logic [7:0] c, logic eoi);
        bit as_text;
        step_beats.delete();
        as_text = (phase == PH_TEXT);
        case (phase)
            PH_START: begin
                if (c == define_word[pre_hits]) begin
                    pre_hits++;
                    if (pre_hits == 7) begin
                        pre_hits = 0;
                        phase = PH_SKIP;
                    end
                end else begin
                    replay_prefix();
                    phase = PH_TEXT;
                    as_text = 1'b1;
                end
            end
            PH_TEXT: begin
                // Text bytes are handled below, line end included.
            end
            PH_SKIP: begin
                if (c == CH_LF) line_reset();
                else phase = PH_GAP_KEY;
            end
            PH_GAP_KEY, PH_GAP_VAL: begin
                if (c == CH_LF) begin
                    line_reset();
                end else if (!is_blank(c)) begin
                    def_char(c, phase == PH_GAP_VAL);
                    phase = (phase == PH_GAP_KEY) ? PH_KEY : PH_VAL;
                end
            end
            PH_KEY: begin
                if (is_blank(c)) begin
                    if (dict_used < NUM_ENTRIES) dict_klen[dict_used] = tok_len;
                    tok_len = 0;
                    if (c == CH_LF) line_reset();
                    else phase = PH_GAP_VAL;
                end else begin
                    def_char(c, 1'b0);
                end
            end
            PH_VAL: begin
                if (is_blank(c)) begin
                    finish_define();
                    if (c == CH_LF) line_reset();
                    else phase = PH_REST;
                end else begin
                    def_char(c, 1'b1);
                end
            end
            default: begin
                if (c == CH_LF) line_reset();
            end
        endcase
        if (as_text) begin
            plain_char(c);
            if (c == CH_LF) line_reset();
        end
        if (eoi) begin
            // End of input flushes whatever is pending on the line.
            if (phase == PH_START && pre_hits > 0) begin
                replay_prefix();
                end_token();
            end else if (phase == PH_TEXT) begin
                end_token();
            end else if (phase == PH_VAL) begin
                finish_define();
            end
            line_reset();
        end
        if (step_beats.size() > 0) step_beats[step_beats.size()-1].last = 1'b1;
        foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
    endfunction

    // ---------------------------------------------------------------
    // Driving and checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        errors++;
    endtask

    // Send one byte. Gaps lower tvalid; tvalid is raised once per step only.
    task automatic send_byte(logic [7:0] c, logic eoi);
        predict_byte(c, eoi);
        while (!no_idle && $urandom_range(99) < 30) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eoi;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_text(string s, bit eoi_at_end);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eoi_at_end && i == s.len() - 1);
    endtask

    // Hold the sender until every expected beat has come, then let the
    // block settle before going on.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // The receiver stalls at random; beats are sampled at the edge that
    // accepts them, so both sides see the values from before the edge.
    always @(posedge clk) begin
        beat_t e;
        cycles <= cycles + 1;
        m_tready <= no_idle || ($urandom_range(99) >= 30);
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_beats.size() == 0) begin
                report_mismatch($sformatf("unexpected beat data=%h user=%b last=%b",
                                          m_tdata, m_tuser, m_tlast));
            end else begin
                e = expected_beats.pop_front();
                if (m_tdata !== {6'b0, e.st, e.ch})
                    report_mismatch($sformatf("data %h, want %h", m_tdata,
                                              {6'b0, e.st, e.ch}));
                if (m_tuser !== e.has)
                    report_mismatch($sformatf("has_char %b, want %b", m_tuser, e.has));
                if (m_tlast !== e.last)
                    report_mismatch($sformatf("last_of_run %b, want %b", m_tlast, e.last));
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d beats outstanding", expected_beats.size());
            $display("text_macro_substitution regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    function automatic string rand_word(int len, bit from_pool);
        string s;
        s = "";
        for (int i = 0; i < len; i++) begin
            if (from_pool) s = {s, string'(8'h61 + $urandom_range(2))};
            else begin
                case ($urandom_range(3))
                    0: s = {s, string'(8'h30 + $urandom_range(9))};
                    1: s = {s, string'(8'h41 + $urandom_range(25))};
                    2: s = {s, string'(8'h61 + $urandom_range(25))};
                    default: s = {s, "_"};
                endcase
            end
        end
        return s;
    endfunction

    // Byte extremes, plain text, whitespace kinds and the NUL byte.
    task automatic test_plain_text();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("ab_9 x\t\013\014\r\n", 1'b0);
        send_text("tail", 1'b1);
    endtask

    // Definitions, substitution, a broken prefix, a short definition line,
    // trailing bytes after the value, an over-long key and end of input
    // inside a value word.
    task automatic test_definitions();
        send_text("$DEFINE foo BarBaz tail ignored\n", 1'b0);
        send_text("(foo) foox foo\n", 1'b0);
        send_text("$DEFINX foo\n", 1'b0);
        send_text("$DEF", 1'b1);
        send_text("$DEFINE lonely\n", 1'b0);
        send_text({"$DEFINE ", rand_word(KEY_MAX + 1, 0), " v\n"}, 1'b0);
        send_text({"$DEFINE k ", rand_word(VAL_MAX + 1, 0), "\n"}, 1'b0);
        send_text("$DEFINE eoi val", 1'b1);
        send_text("eoi", 1'b1);
        // A token longer than the key limit passes straight through.
        send_text({rand_word(KEY_MAX + 5, 0), " foo\n"}, 1'b0);
        send_text({"$DEFINE ", rand_word(KEY_MAX, 0), " ",
                   rand_word(VAL_MAX, 0), "\n"}, 1'b0);
    endtask

    // Mostly well-formed lines with random content, plus noise and broken
    // prefixes; a stretch without any idling on either side.
    task automatic test_random_streams(int budget);
        string line;
        int    n;
        while (bytes_sent < budget) begin
            no_idle = (bytes_sent > budget / 2 && bytes_sent < budget / 2 + 60);
            line = "";
            case ($urandom_range(9))
                0, 1, 2: line = {"$DEFINE", string'($urandom_range(8'h21, 8'h7E)),
                                 rand_word($urandom_range(1, 4), 1), " ",
                                 rand_word($urandom_range(1, 6), 0), "\n"};
                3: line = {"$DEFINE ", rand_word($urandom_range(30, 36), 0), " ",
                           rand_word($urandom_range(30, 36), 0), "\n"};
                4: line = {"$DEFI", rand_word(2, 1), "\n"};
                5: begin
                    n = $urandom_range(1, 8);
                    for (int i = 0; i < n; i++)
                        line = {line, string'($urandom_range(255))};
                end
                default: begin
                    n = $urandom_range(1, 5);
                    for (int i = 0; i < n; i++)
                        line = {line, rand_word($urandom_range(1, 4), 1),
                                ($urandom_range(1) ? " " : "+")};
                    line = {line, "\n"};
                end
            endcase
            send_text(line, $urandom_range(19) == 0);
        end
        no_idle = 1'b0;
    endtask

    // Fill the table to its limit, then one more definition is rejected.
    task automatic test_table_full();
        int i;
        i = 0;
        while (dict_used < NUM_ENTRIES) begin
            send_text($sformatf("$DEFINE z%0d v%0d\n", i, i), 1'b0);
            i++;
        end
        send_text("$DEFINE over flow\n", 1'b0);
        send_text("z0 over\n", 1'b1);
    endtask

    initial begin
        dict_used = 0;
        line_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_plain_text();
        test_definitions();
        drain();
        test_random_streams(bytes_sent + 320);
        test_table_full();
        drain();
        if (errors == 0)
            $display("text_macro_substitution regression: pass");
        else
            $display("text_macro_substitution regression: fail");
        $finish;
    end

endmodule
